>>> rtl/tcf_pkg.sv
package tcf_pkg;

    // field widths
    localparam int IN_W       = 16;
    localparam int DT_W       = 20;
    localparam int WGT_W      = 17;
    localparam int TILT_W     = 19;
    localparam int ACC_W      = 17;
    localparam int RATE_W     = 17;
    localparam int INC_W      = 18;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 2;

    // angle format
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int Q16_TO_OUT      = 16 - ANGLE_FRAC_BITS;
    localparam int ROUND_HALF      = 1 << (Q16_TO_OUT - 1);
    localparam int ANG_LIM         = 180 << ANGLE_FRAC_BITS;
    localparam int ACC_HI          = (ANG_LIM < 65535) ? ANG_LIM : 65535;
    localparam int ACC_LO          = (-ANG_LIM > -65536) ? -ANG_LIM : -65536;

    // cordic
    localparam int CORDIC_STEPS    = 16;
    localparam int CORDIC_CNT_W    = $clog2(CORDIC_STEPS);
    localparam int ATAN_LEN        = 24;
    localparam int ATAN_IDX_W      = $clog2(ATAN_LEN);
    localparam int CORDIC_PRESCALE = 14;
    localparam int CORDIC_XY_W     = 32;
    localparam int CORDIC_Z_W      = 25;
    localparam int ROT90_Q16       = 90 * 65536;

    // serial divider
    localparam int DEN_W     = 20;
    localparam int DIV_QW    = (ANGLE_FRAC_BITS > 8) ? ANGLE_FRAC_BITS + 9 : 17;
    localparam int DIV_W     = DEN_W + DIV_QW;
    localparam int DIV_CNT_W = $clog2(DIV_QW);
    localparam int RATE_DEN  = 131;
    localparam int RATE_HALF = RATE_DEN / 2;
    localparam int INC_DEN   = 1000000;
    localparam int INC_HALF  = INC_DEN / 2;
    localparam int INC_PROD_W = RATE_W + DT_W;

    // limits and weights
    localparam int RATE_POS_MAX = 65535;
    localparam int RATE_NEG_MAG = 65536;
    localparam int ONE_Q16      = 65536;
    localparam int BLEND_W      = 38;
    localparam int BLEND_RND    = 32768;
    localparam int TILT_MAX     = 262143;
    localparam int TILT_MIN     = -262144;

    // register reset values
    localparam int GYRO_OFFSET_RST = -59;
    localparam int GYRO_WEIGHT_RST = 64225;
    localparam int DT_MIN_RST      = 1000;
    localparam int DT_MAX_RST      = 50000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GYRO_OFFSET = 2'd0,
        REG_GYRO_WEIGHT = 2'd1,
        REG_DT_MIN      = 2'd2,
        REG_DT_MAX      = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic [DIV_QW-1:0] quo;
    } div_rsp_t;

    typedef struct packed {
        logic                   start;
        logic signed [IN_W-1:0] ax;
        logic signed [IN_W-1:0] az;
    } cordic_req_t;

    typedef struct packed {
        logic                    busy;
        logic signed [ACC_W-1:0] angle;
    } cordic_rsp_t;

    // atan(2^-i) in 1/65536 degree
    function automatic logic signed [CORDIC_Z_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [CORDIC_Z_W-1:0] v;
        case (idx)
            5'd0:    v = 25'sd2949120;
            5'd1:    v = 25'sd1740967;
            5'd2:    v = 25'sd919879;
            5'd3:    v = 25'sd466945;
            5'd4:    v = 25'sd234379;
            5'd5:    v = 25'sd117304;
            5'd6:    v = 25'sd58666;
            5'd7:    v = 25'sd29335;
            5'd8:    v = 25'sd14668;
            5'd9:    v = 25'sd7334;
            5'd10:   v = 25'sd3667;
            5'd11:   v = 25'sd1833;
            5'd12:   v = 25'sd917;
            5'd13:   v = 25'sd458;
            5'd14:   v = 25'sd229;
            5'd15:   v = 25'sd115;
            5'd16:   v = 25'sd57;
            5'd17:   v = 25'sd29;
            5'd18:   v = 25'sd14;
            5'd19:   v = 25'sd7;
            5'd20:   v = 25'sd4;
            5'd21:   v = 25'sd2;
            5'd22:   v = 25'sd1;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/tcf_in_if.sv
interface tcf_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [tcf_pkg::IN_W-1:0]  accel_x;
    logic signed [tcf_pkg::IN_W-1:0]  accel_z;
    logic signed [tcf_pkg::IN_W-1:0]  gyro_x;
    logic        [tcf_pkg::DT_W-1:0]  elapsed_us;

    modport source (output valid, output accel_x, output accel_z, output gyro_x,
                    output elapsed_us, input ready);
    modport sink (input valid, input accel_x, input accel_z, input gyro_x,
                  input elapsed_us, output ready);
endinterface

>>> rtl/tcf_out_if.sv
interface tcf_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [tcf_pkg::TILT_W-1:0] tilt_angle;
    logic signed [tcf_pkg::ACC_W-1:0]  accel_angle;
    logic signed [tcf_pkg::RATE_W-1:0] rate_dps;

    modport source (output valid, output tilt_angle, output accel_angle, output rate_dps,
                    input ready);
    modport sink (input valid, input tilt_angle, input accel_angle, input rate_dps,
                  output ready);
endinterface

>>> rtl/tcf_div.sv
module tcf_div (
    input  logic              clk,
    input  logic              rst_n,
    input  tcf_pkg::div_req_t req,
    output tcf_pkg::div_rsp_t rsp
);

    logic                              busy_reg, busy_next;
    logic [tcf_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [tcf_pkg::DIV_W-1:0]         rem_reg, rem_next;
    logic [tcf_pkg::DIV_W-1:0]         dsh_reg, dsh_next;
    logic [tcf_pkg::DIV_QW-1:0]        quo_reg, quo_next;
    logic                              ge;

    // restoring division, one quotient bit per cycle, msb first
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        ge        = (rem_reg >= dsh_reg);
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = tcf_pkg::DIV_CNT_W'(tcf_pkg::DIV_QW - 1);
            rem_next  = req.num;
            dsh_next  = tcf_pkg::DIV_W'(req.den) << (tcf_pkg::DIV_QW - 1);
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            quo_next = {quo_reg[tcf_pkg::DIV_QW-2:0], ge};
            dsh_next = dsh_reg >> 1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.quo  = quo_reg;

endmodule

>>> rtl/tcf_cordic.sv
module tcf_cordic (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcf_pkg::cordic_req_t req,
    output tcf_pkg::cordic_rsp_t rsp
);

    localparam logic signed [tcf_pkg::CORDIC_Z_W-1:0] ACC_HI_Z =
        tcf_pkg::CORDIC_Z_W'(tcf_pkg::ACC_HI);
    localparam logic signed [tcf_pkg::CORDIC_Z_W-1:0] ACC_LO_Z =
        tcf_pkg::CORDIC_Z_W'(tcf_pkg::ACC_LO);
    localparam int PAD_W = tcf_pkg::CORDIC_XY_W - tcf_pkg::IN_W - tcf_pkg::CORDIC_PRESCALE;

    logic                                      busy_reg, busy_next;
    logic [tcf_pkg::CORDIC_CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [tcf_pkg::CORDIC_XY_W-1:0]    x_reg, x_next, y_reg, y_next;
    logic signed [tcf_pkg::CORDIC_Z_W-1:0]     z_reg, z_next;
    logic signed [tcf_pkg::ACC_W-1:0]          angle_reg, angle_next;
    logic signed [tcf_pkg::CORDIC_XY_W-1:0]    x0, y0, xs, ys, x_step, y_step;
    logic signed [tcf_pkg::CORDIC_Z_W-1:0]     z_step, z_rnd, atan_v;

    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        angle_next = angle_reg;

        x0 = $signed({{PAD_W{req.az[tcf_pkg::IN_W-1]}}, req.az,
                      {tcf_pkg::CORDIC_PRESCALE{1'b0}}});
        y0 = $signed({{PAD_W{req.ax[tcf_pkg::IN_W-1]}}, req.ax,
                      {tcf_pkg::CORDIC_PRESCALE{1'b0}}});

        xs     = x_reg >>> cnt_reg;
        ys     = y_reg >>> cnt_reg;
        atan_v = tcf_pkg::atan_q16(tcf_pkg::ATAN_IDX_W'(cnt_reg));
        if (!y_reg[tcf_pkg::CORDIC_XY_W-1])
        begin
            x_step = x_reg + ys;
            y_step = y_reg - xs;
            z_step = z_reg + atan_v;
        end
        else
        begin
            x_step = x_reg - ys;
            y_step = y_reg + xs;
            z_step = z_reg - atan_v;
        end
        z_rnd = (z_step + tcf_pkg::CORDIC_Z_W'(tcf_pkg::ROUND_HALF)) >>> tcf_pkg::Q16_TO_OUT;

        if (req.start)
        begin
            if (req.ax == '0 && req.az == '0)
            begin
                // zero vector reads as level
                angle_next = '0;
                busy_next  = 1'b0;
            end
            else
            begin
                busy_next = 1'b1;
                cnt_next  = '0;
                if (!req.az[tcf_pkg::IN_W-1])
                begin
                    x_next = x0;
                    y_next = y0;
                    z_next = '0;
                end
                else if (!req.ax[tcf_pkg::IN_W-1])
                begin
                    x_next = y0;
                    y_next = -x0;
                    z_next = tcf_pkg::CORDIC_Z_W'(tcf_pkg::ROT90_Q16);
                end
                else
                begin
                    x_next = -y0;
                    y_next = x0;
                    z_next = -tcf_pkg::CORDIC_Z_W'(tcf_pkg::ROT90_Q16);
                end
            end
        end
        else if (busy_reg)
        begin
            x_next = x_step;
            y_next = y_step;
            z_next = z_step;
            if (cnt_reg == tcf_pkg::CORDIC_CNT_W'(tcf_pkg::CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                if (z_rnd > ACC_HI_Z)
                begin
                    angle_next = tcf_pkg::ACC_W'(tcf_pkg::ACC_HI);
                end
                else if (z_rnd < ACC_LO_Z)
                begin
                    angle_next = tcf_pkg::ACC_W'(tcf_pkg::ACC_LO);
                end
                else
                begin
                    angle_next = z_rnd[tcf_pkg::ACC_W-1:0];
                end
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        angle_reg <= angle_next;
    end

    assign rsp.busy  = busy_reg;
    assign rsp.angle = angle_reg;

endmodule

>>> rtl/tilt_complementary_filter_top.sv
// channel   dir  beat fields                                   handshake
// sample    in   accel_x, accel_z, gyro_x, elapsed_us         valid/ready
// result    out  tilt_angle, accel_angle, rate_dps            valid/ready
// cfg       in   cfg_index, cfg_data                          cfg_we, no wait
//
// one sample at a time; the bit-serial divider (one quotient bit per cycle) is used
// first for the rate and then for the gyro increment; the cordic runs beside the
// first pass.
// rst_n clears the filtered angle to zero and loads the register reset values.
// the result sits in an output register; a stalled result only holds the block
// when the next result is ready to load.
module tilt_complementary_filter_top (
    input  logic                               clk,
    input  logic                               rst_n,
    tcf_in_if.sink                             sample,
    tcf_out_if.source                          result,
    input  logic                               cfg_we,
    input  logic [tcf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tcf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_RATE    = 8'b0000_0010,
        ST_INC_MUL = 8'b0000_0100,
        ST_INC     = 8'b0000_1000,
        ST_BLEND_A = 8'b0001_0000,
        ST_BLEND_B = 8'b0010_0000,
        ST_BLEND_C = 8'b0100_0000,
        ST_DONE    = 8'b1000_0000
    } tcf_state_t;

    localparam logic signed [tcf_pkg::BLEND_W-1:0] TILT_MAX_B =
        tcf_pkg::BLEND_W'(tcf_pkg::TILT_MAX);
    localparam logic signed [tcf_pkg::BLEND_W-1:0] TILT_MIN_B =
        tcf_pkg::BLEND_W'(tcf_pkg::TILT_MIN);

    tcf_state_t                                state_reg, state_next;

    logic signed [tcf_pkg::IN_W-1:0]           off_reg, off_next;
    logic [tcf_pkg::WGT_W-1:0]                 wgt_reg, wgt_next;
    logic [tcf_pkg::DT_W-1:0]                  dtmin_reg, dtmin_next;
    logic [tcf_pkg::DT_W-1:0]                  dtmax_reg, dtmax_next;

    logic signed [tcf_pkg::TILT_W-1:0]         angle_reg, angle_next;
    logic [tcf_pkg::DT_W-1:0]                  dt_reg, dt_next;
    logic                                      neg_reg, neg_next;
    logic signed [tcf_pkg::RATE_W-1:0]         rate_reg, rate_next;
    logic signed [tcf_pkg::INC_W-1:0]          inc_reg, inc_next;
    logic signed [tcf_pkg::ACC_W-1:0]          acc_reg, acc_next;
    logic signed [tcf_pkg::BLEND_W-1:0]        p1_reg, p1_next, p2_reg, p2_next;

    logic                                      out_valid_reg, out_valid_next;
    logic signed [tcf_pkg::TILT_W-1:0]         tilt_out_reg, tilt_out_next;
    logic signed [tcf_pkg::ACC_W-1:0]          acc_out_reg, acc_out_next;
    logic signed [tcf_pkg::RATE_W-1:0]         rate_out_reg, rate_out_next;

    tcf_pkg::div_req_t                         div_req;
    tcf_pkg::div_rsp_t                         div_rsp;
    tcf_pkg::cordic_req_t                      cordic_req;
    tcf_pkg::cordic_rsp_t                      cordic_rsp;

    logic                                      accept;
    logic [tcf_pkg::DT_W-1:0]                  dt_lo, dt_cl;
    logic signed [tcf_pkg::RATE_W-1:0]         diff;
    logic [tcf_pkg::RATE_W-1:0]                diff_mag;
    logic [tcf_pkg::DIV_W-1:0]                 rate_num;
    logic [tcf_pkg::DIV_QW-1:0]                rate_q;
    logic [tcf_pkg::RATE_W-1:0]                rate_mag;
    logic [tcf_pkg::INC_PROD_W-1:0]            inc_num;
    logic [tcf_pkg::INC_W-2:0]                 inc_q;
    logic [tcf_pkg::WGT_W-1:0]                 w_c, w_inv;
    logic signed [tcf_pkg::TILT_W:0]           blend_s;
    logic signed [tcf_pkg::BLEND_W-1:0]        blend_sum, blend_sh;

    assign accept       = sample.valid && sample.ready;
    assign sample.ready = (state_reg == ST_IDLE);

    tcf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    tcf_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cordic_req),
        .rsp   (cordic_rsp)
    );

    // configuration writes
    always_comb
    begin
        off_next   = off_reg;
        wgt_next   = wgt_reg;
        dtmin_next = dtmin_reg;
        dtmax_next = dtmax_reg;
        if (cfg_we)
        begin
            unique case (tcf_pkg::cfg_reg_t'(cfg_index))
                tcf_pkg::REG_GYRO_OFFSET: off_next   = cfg_data[tcf_pkg::IN_W-1:0];
                tcf_pkg::REG_GYRO_WEIGHT: wgt_next   = cfg_data[tcf_pkg::WGT_W-1:0];
                tcf_pkg::REG_DT_MIN:      dtmin_next = cfg_data[tcf_pkg::DT_W-1:0];
                tcf_pkg::REG_DT_MAX:      dtmax_next = cfg_data[tcf_pkg::DT_W-1:0];
                default: ;
            endcase
        end
    end

    // datapath helpers
    always_comb
    begin
        // lower clamp first, so the upper one wins when they cross
        dt_lo = (sample.elapsed_us < dtmin_reg) ? dtmin_reg : sample.elapsed_us;
        dt_cl = (dt_lo > dtmax_reg) ? dtmax_reg : dt_lo;

        diff     = $signed({sample.gyro_x[tcf_pkg::IN_W-1], sample.gyro_x})
                 - $signed({off_reg[tcf_pkg::IN_W-1], off_reg});
        diff_mag = diff[tcf_pkg::RATE_W-1] ? tcf_pkg::RATE_W'(-diff) : diff;
        rate_num = (tcf_pkg::DIV_W'(diff_mag) << tcf_pkg::ANGLE_FRAC_BITS)
                 + tcf_pkg::DIV_W'(tcf_pkg::RATE_HALF);

        // saturate the rate magnitude before signing
        if (neg_reg)
        begin
            rate_q = (div_rsp.quo > tcf_pkg::DIV_QW'(tcf_pkg::RATE_NEG_MAG)) ?
                     tcf_pkg::DIV_QW'(tcf_pkg::RATE_NEG_MAG) : div_rsp.quo;
        end
        else
        begin
            rate_q = (div_rsp.quo > tcf_pkg::DIV_QW'(tcf_pkg::RATE_POS_MAX)) ?
                     tcf_pkg::DIV_QW'(tcf_pkg::RATE_POS_MAX) : div_rsp.quo;
        end

        rate_mag = rate_reg[tcf_pkg::RATE_W-1] ? tcf_pkg::RATE_W'(-rate_reg) : rate_reg;
        inc_num  = rate_mag * dt_reg + tcf_pkg::INC_PROD_W'(tcf_pkg::INC_HALF);
        inc_q    = div_rsp.quo[tcf_pkg::INC_W-2:0];

        w_c   = (wgt_reg > tcf_pkg::WGT_W'(tcf_pkg::ONE_Q16)) ?
                tcf_pkg::WGT_W'(tcf_pkg::ONE_Q16) : wgt_reg;
        w_inv = tcf_pkg::WGT_W'(tcf_pkg::ONE_Q16) - w_c;

        blend_s   = $signed({angle_reg[tcf_pkg::TILT_W-1], angle_reg})
                  + $signed({{(tcf_pkg::TILT_W + 1 - tcf_pkg::INC_W){inc_reg[tcf_pkg::INC_W-1]}},
                             inc_reg});
        blend_sum = p1_reg + p2_reg + tcf_pkg::BLEND_W'(tcf_pkg::BLEND_RND);
        blend_sh  = blend_sum >>> 16;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        angle_next     = angle_reg;
        dt_next        = dt_reg;
        neg_next       = neg_reg;
        rate_next      = rate_reg;
        inc_next       = inc_reg;
        acc_next       = acc_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        tilt_out_next  = tilt_out_reg;
        acc_out_next   = acc_out_reg;
        rate_out_next  = rate_out_reg;
        out_valid_next = out_valid_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        div_req.start    = 1'b0;
        div_req.num      = rate_num;
        div_req.den      = tcf_pkg::DEN_W'(tcf_pkg::RATE_DEN);
        cordic_req.start = 1'b0;
        cordic_req.ax    = sample.accel_x;
        cordic_req.az    = sample.accel_z;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    dt_next          = dt_cl;
                    neg_next         = diff[tcf_pkg::RATE_W-1];
                    div_req.start    = 1'b1;
                    cordic_req.start = 1'b1;
                    state_next       = ST_RATE;
                end
            end
            ST_RATE:
            begin
                if (!div_rsp.busy)
                begin
                    rate_next  = neg_reg ? -$signed(rate_q[tcf_pkg::RATE_W-1:0])
                                         : $signed(rate_q[tcf_pkg::RATE_W-1:0]);
                    state_next = ST_INC_MUL;
                end
            end
            ST_INC_MUL:
            begin
                div_req.start = 1'b1;
                div_req.num   = tcf_pkg::DIV_W'(inc_num);
                div_req.den   = tcf_pkg::DEN_W'(tcf_pkg::INC_DEN);
                state_next    = ST_INC;
            end
            ST_INC:
            begin
                if (!div_rsp.busy && !cordic_rsp.busy)
                begin
                    inc_next   = rate_reg[tcf_pkg::RATE_W-1] ? -$signed({1'b0, inc_q})
                                                             : $signed({1'b0, inc_q});
                    acc_next   = cordic_rsp.angle;
                    state_next = ST_BLEND_A;
                end
            end
            ST_BLEND_A:
            begin
                p1_next    = $signed({1'b0, w_c}) * blend_s;
                state_next = ST_BLEND_B;
            end
            ST_BLEND_B:
            begin
                p2_next    = $signed({1'b0, w_inv}) * acc_reg;
                state_next = ST_BLEND_C;
            end
            ST_BLEND_C:
            begin
                if (blend_sh > TILT_MAX_B)
                begin
                    angle_next = tcf_pkg::TILT_W'(tcf_pkg::TILT_MAX);
                end
                else if (blend_sh < TILT_MIN_B)
                begin
                    angle_next = tcf_pkg::TILT_W'(tcf_pkg::TILT_MIN);
                end
                else
                begin
                    angle_next = blend_sh[tcf_pkg::TILT_W-1:0];
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    tilt_out_next  = angle_reg;
                    acc_out_next   = acc_reg;
                    rate_out_next  = rate_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            angle_reg     <= '0;
            off_reg       <= tcf_pkg::IN_W'(tcf_pkg::GYRO_OFFSET_RST);
            wgt_reg       <= tcf_pkg::WGT_W'(tcf_pkg::GYRO_WEIGHT_RST);
            dtmin_reg     <= tcf_pkg::DT_W'(tcf_pkg::DT_MIN_RST);
            dtmax_reg     <= tcf_pkg::DT_W'(tcf_pkg::DT_MAX_RST);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            angle_reg     <= angle_next;
            off_reg       <= off_next;
            wgt_reg       <= wgt_next;
            dtmin_reg     <= dtmin_next;
            dtmax_reg     <= dtmax_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg       <= dt_next;
        neg_reg      <= neg_next;
        rate_reg     <= rate_next;
        inc_reg      <= inc_next;
        acc_reg      <= acc_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        tilt_out_reg <= tilt_out_next;
        acc_out_reg  <= acc_out_next;
        rate_out_reg <= rate_out_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.tilt_angle  = tilt_out_reg;
    assign result.accel_angle = acc_out_reg;
    assign result.rate_dps    = rate_out_reg;

endmodule

>>> tb/tilt_complementary_filter_top_tb.sv
`timescale 1ns / 1ps

module tilt_complementary_filter_top_tb;
    import tcf_pkg::*;

    localparam int     CYCLE_LIMIT   = 1000000;
    localparam int     SETTLE_CYCLES = 64;
    localparam int     RANDOM_PHASES = 8;
    localparam int     PHASE_ITEMS   = 88;
    localparam int     HOLD_CYCLES   = 400;
    localparam int     FRAC          = ANGLE_FRAC_BITS;
    localparam int     Q16_SHIFT     = 16 - FRAC;
    localparam longint ATAN_STEP [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct {
        logic signed [TILT_W-1:0] tilt;
        logic signed [ACC_W-1:0]  accel;
        logic signed [RATE_W-1:0] rate;
    } tilt_beat_t;

    class tilt_tracker;
        longint     offset;
        longint     weight;
        longint     dt_lo;
        longint     dt_hi;
        longint     angle;
        int         errors;
        int         checked;
        int         samples;
        tilt_beat_t pending_tilts[$];

        function void reset_state();
            offset = -59;
            weight = 64225;
            dt_lo  = 1000;
            dt_hi  = 50000;
            angle  = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_GYRO_OFFSET: offset = longint'($signed(value[15:0]));
                REG_GYRO_WEIGHT: weight = longint'(value[16:0]);
                REG_DT_MIN:      dt_lo  = longint'(value[19:0]);
                REG_DT_MAX:      dt_hi  = longint'(value[19:0]);
                default:         ;
            endcase
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        // round half away from zero
        function longint div_nearest(longint num, longint den);
            longint mag;
            mag = (num < 0) ? -num : num;
            mag = (mag + den / 2) / den;
            return (num < 0) ? -mag : mag;
        endfunction

        function longint accel_tilt(longint ax, longint az);
            longint x, y, z, t, xs, ys;
            if (ax == 0 && az == 0)
                return 0;
            x = az * 16384;
            y = ax * 16384;
            z = 0;
            // fold the left half plane onto the right one first
            if (x < 0)
            begin
                t = x;
                if (y >= 0)
                begin
                    x = y;
                    y = -t;
                    z = 90 * 65536;
                end
                else
                begin
                    x = -y;
                    y = t;
                    z = -90 * 65536;
                end
            end
            for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_STEP[i];
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_STEP[i];
                end
            end
            z = (z + (longint'(1) << (Q16_SHIFT - 1))) >>> Q16_SHIFT;
            z = clip(z, -(longint'(180) << FRAC), longint'(180) << FRAC);
            return clip(z, -65536, 65535);
        endfunction

        function void take_sample(logic signed [15:0] ax, logic signed [15:0] az,
                                  logic signed [15:0] gx, logic [19:0] elapsed);
            longint     dt, w, rate, acc, inc, blend;
            tilt_beat_t beat;
            dt = longint'(elapsed);
            w  = (weight > 65536) ? 65536 : weight;
            if (dt < dt_lo)
                dt = dt_lo;
            if (dt > dt_hi)
                dt = dt_hi;
            rate  = div_nearest((longint'(gx) - offset) * (longint'(1) << FRAC), 131);
            rate  = clip(rate, -65536, 65535);
            acc   = accel_tilt(longint'(ax), longint'(az));
            inc   = div_nearest(rate * dt, 1000000);
            blend = w * (angle + inc) + (65536 - w) * acc;
            blend = (blend + 32768) >>> 16;
            angle = clip(blend, -262144, 262143);
            beat.tilt  = angle[TILT_W-1:0];
            beat.accel = acc[ACC_W-1:0];
            beat.rate  = rate[RATE_W-1:0];
            pending_tilts.push_back(beat);
            samples++;
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_result(logic signed [TILT_W-1:0] tilt, logic signed [ACC_W-1:0] accel,
                          logic signed [RATE_W-1:0] rate);
            tilt_beat_t want;
            if (pending_tilts.size() == 0)
            begin
                report($sformatf("result beat with nothing pending, tilt %0d", tilt));
            end
            else
            begin
                want = pending_tilts.pop_front();
                checked++;
                if (tilt !== want.tilt || accel !== want.accel || rate !== want.rate)
                    report($sformatf("beat %0d got/want tilt %0d/%0d accel %0d/%0d rate %0d/%0d",
                                     checked, tilt, want.tilt, accel, want.accel,
                                     rate, want.rate));
            end
        endtask

        function int pending();
            return pending_tilts.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    idle_pct = 0;
    int                    stall_pct = 0;
    int                    hold_len = 0;
    int                    cycle_count = 0;
    int                    settings_used = 0;
    tilt_tracker           tracker;

    tcf_in_if  sample_if ();
    tcf_out_if result_if ();

    tilt_complementary_filter_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_if),
        .result    (result_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycle_count, tracker.pending());
            $display("tilt_complementary_filter_top_tb: done, errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (sample_if.valid && sample_if.ready)
            tracker.take_sample(sample_if.accel_x, sample_if.accel_z, sample_if.gyro_x,
                                sample_if.elapsed_us);
        if (result_if.valid && result_if.ready)
            tracker.check_result(result_if.tilt_angle, result_if.accel_angle,
                                 result_if.rate_dps);
    end

    // result side: random stalls plus a single long hold-off
    initial
    begin
        int n;
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_len != 0)
            begin
                n = hold_len;
                hold_len = 0;
                result_if.ready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            result_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_sample(input logic signed [15:0] ax, input logic signed [15:0] az,
                               input logic signed [15:0] gx, input logic [19:0] elapsed);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            sample_if.valid <= 1'b0;
            @(negedge clk);
        end
        sample_if.valid      <= 1'b1;
        sample_if.accel_x    <= ax;
        sample_if.accel_z    <= az;
        sample_if.gyro_x     <= gx;
        sample_if.elapsed_us <= elapsed;
        @(posedge clk);
        while (!sample_if.ready)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        tracker.set_reg(idx, value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // stop offering, wait for every pending beat, then let the block settle
    task automatic drain();
        @(negedge clk);
        sample_if.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [15:0] corner_value();
        case ($urandom_range(0, 4))
            0:       return 16'sd0;
            1:       return 16'sd1;
            2:       return -16'sd1;
            3:       return 16'sd32767;
            default: return -16'sd32768;
        endcase
    endfunction

    task automatic pick_settings(input int phase);
        int pick;
        pick = $urandom_range(0, 3);
        settings_used++;
        if (phase == 0)
        begin
            write_reg(REG_GYRO_OFFSET, -59);
            write_reg(REG_GYRO_WEIGHT, 64225);
            write_reg(REG_DT_MIN, 1000);
            write_reg(REG_DT_MAX, 50000);
        end
        else
        begin
            write_reg(REG_GYRO_OFFSET, (pick == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 400) - 200);
            write_reg(REG_GYRO_WEIGHT, (pick == 0) ? $urandom_range(0, 131071)
                                                   : $urandom_range(60000, 65536));
            // pick 1 allows crossed clamps
            write_reg(REG_DT_MIN, (pick == 1) ? $urandom_range(0, 1048575)
                                              : $urandom_range(0, 3000));
            write_reg(REG_DT_MAX, (pick == 1) ? $urandom_range(0, 1048575)
                                              : $urandom_range(20000, 1048575));
        end
    endtask

    task automatic random_sample();
        logic signed [15:0] ax, az, gx;
        logic [19:0]        elapsed;
        int                 shape;
        shape = $urandom_range(0, 9);
        if (shape < 5)
        begin
            ax = $urandom;
            az = $urandom;
            gx = $urandom;
        end
        else if (shape < 9)
        begin
            // sensor near rest, gravity around 16384 counts
            ax = $urandom_range(0, 32768) - 16384;
            az = $urandom_range(0, 32768) - 16384;
            gx = $urandom_range(0, 4000) - 2000;
        end
        else
        begin
            ax = corner_value();
            az = corner_value();
            gx = corner_value();
        end
        shape = $urandom_range(0, 9);
        if (shape < 5)
            elapsed = $urandom_range(0, 60000);
        else if (shape < 8)
            elapsed = $urandom;
        else
            case ($urandom_range(0, 5))
                0:       elapsed = 20'd0;
                1:       elapsed = tracker.dt_lo;
                2:       elapsed = tracker.dt_lo - 1;
                3:       elapsed = tracker.dt_hi;
                4:       elapsed = tracker.dt_hi + 1;
                default: elapsed = 20'hFFFFF;
            endcase
        send_sample(ax, az, gx, elapsed);
    endtask

    initial
    begin
        tracker = new();
        tracker.reset_state();
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = REG_GYRO_OFFSET;
        cfg_data             = '0;
        sample_if.valid      = 1'b0;
        sample_if.accel_x    = '0;
        sample_if.accel_z    = '0;
        sample_if.gyro_x     = '0;
        sample_if.elapsed_us = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: zero vector, every quadrant, clamp edges
        settings_used++;
        send_sample(0, 0, 0, 0);
        send_sample(0, 16384, -59, 1000);
        send_sample(16384, 0, 0, 20000);
        send_sample(-16384, 0, 131, 999);
        send_sample(0, -16384, -190, 50001);
        send_sample(-1, -32768, 500, 49999);
        send_sample(32767, 32767, 32767, 1048575);
        send_sample(-32768, -32768, -32768, 50000);
        send_sample(-32768, 32767, 100, 1001);
        send_sample(1, 0, -1, 12345);
        drain();

        // full weight and widest clamps: drive the angle into positive saturation
        settings_used++;
        write_reg(REG_GYRO_OFFSET, -32768);
        write_reg(REG_GYRO_WEIGHT, 65536);
        write_reg(REG_DT_MIN, 0);
        write_reg(REG_DT_MAX, 1048575);
        repeat (5) send_sample(16384, 16384, 32767, 1048575);
        send_sample(0, 16384, 0, 0);
        drain();

        // weight above one, crossed clamps, then negative saturation
        settings_used++;
        write_reg(REG_GYRO_OFFSET, 32767);
        write_reg(REG_GYRO_WEIGHT, 131071);
        write_reg(REG_DT_MIN, 1048575);
        write_reg(REG_DT_MAX, 0);
        send_sample(-16384, 16384, -32768, 500);
        drain();
        write_reg(REG_DT_MAX, 1048575);
        repeat (8) send_sample(-16384, -16384, -32768, 0);
        drain();
        write_reg(REG_GYRO_WEIGHT, 0);
        send_sample(0, -32768, 0, 2000);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            pick_settings(p);
            @(posedge clk);
            idle_pct  = (p % 4 == 1) ? 50 : ((p % 4 == 3) ? 31 : 0);
            stall_pct = (p % 4 == 2) ? 50 : ((p % 4 == 3) ? 31 : 0);
            if (p == 2)
                hold_len = HOLD_CYCLES;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p == 5 && k == PHASE_ITEMS / 2)
                    drain();
                random_sample();
            end
        end
        drain();

        $display("covered %0d samples under %0d register settings, %0d results compared",
                 tracker.samples, settings_used, tracker.checked);
        $display("idle and stall mixes included a %0d-cycle result hold-off", HOLD_CYCLES);
        if (tracker.errors == 0)
            $display("tilt_complementary_filter_top_tb: done, clean");
        else
            $display("tilt_complementary_filter_top_tb: done, errors");
        $finish;
    end

endmodule
